@@ design/mtet_pkg.sv @@
package mtet_pkg;

    // Field widths.
    localparam int IDENT_W = 11;
    localparam int ANGLE_W = 16;
    localparam int TURNS_W = 16;
    localparam int LOC_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_NUM_AXES = 2;
    localparam int QUEUE_DEPTH      = 2;

    // Axis codes.
    localparam logic AXIS_PITCH = 1'b0;
    localparam logic AXIS_YAW   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_IDENT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_IDENT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_TURN = 3'd4;

    // Register reset values.
    localparam logic [IDENT_W-1:0] RST_PITCH_IDENT     = 11'd517;
    localparam logic [IDENT_W-1:0] RST_YAW_IDENT       = 11'd518;
    localparam logic [ANGLE_W-1:0] RST_LOW_THRESHOLD   = 16'd2000;
    localparam logic [ANGLE_W-1:0] RST_HIGH_THRESHOLD  = 16'd5000;
    localparam logic [ANGLE_W-1:0] RST_COUNTS_PER_TURN = 16'd8191;

    // A classified request waiting for the back end.
    typedef struct packed {
        logic               axis;
        logic [ANGLE_W-1:0] angle;
    } item_t;

    // Configuration as seen by the front and back ends.
    typedef struct packed {
        logic [IDENT_W-1:0] pitch_ident;
        logic [IDENT_W-1:0] yaw_ident;
        logic [ANGLE_W-1:0] low_threshold;
        logic [ANGLE_W-1:0] high_threshold;
        logic [ANGLE_W-1:0] counts_per_turn;
    } cfg_t;

endpackage

@@ design/mtet_front.sv @@
module mtet_front #(
    parameter int NUM_AXES = mtet_pkg::DEFAULT_NUM_AXES
) (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mtet_pkg::IDENT_W-1:0] s_msg_ident,
    input  logic [mtet_pkg::ANGLE_W-1:0] s_angle,
    input  mtet_pkg::cfg_t               cfg,
    output logic                         push_valid,
    input  logic                         push_ready,
    output mtet_pkg::item_t              push_item
);
    import mtet_pkg::*;

    logic pitch_hit;
    logic yaw_hit;

    // Pitch wins when both identifiers match; yaw exists only with a second axis.
    assign pitch_hit = (s_msg_ident == cfg.pitch_ident);
    assign yaw_hit   = (s_msg_ident == cfg.yaw_ident) && (NUM_AXES > 1);

    // Unmatched requests are taken and dropped; matched ones go into the queue.
    assign s_ready        = push_ready;
    assign push_valid     = s_valid && (pitch_hit || yaw_hit);
    assign push_item.axis  = pitch_hit ? AXIS_PITCH : AXIS_YAW;
    assign push_item.angle = s_angle;

endmodule

@@ design/mtet_fifo.sv @@
module mtet_fifo #(
    parameter int DEPTH = mtet_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  mtet_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mtet_pkg::item_t pop_item
);
    import mtet_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/mtet_back.sv @@
module mtet_back #(
    parameter int NUM_AXES = mtet_pkg::DEFAULT_NUM_AXES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mtet_pkg::cfg_t                      cfg,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  mtet_pkg::item_t                     pop_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_axis,
    output logic signed [mtet_pkg::LOC_W-1:0]   m_location,
    output logic signed [mtet_pkg::TURNS_W-1:0] m_turn_count
);
    import mtet_pkg::*;

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Per-axis tracking state.
    logic               first_seen_reg [NUM_AXES];
    logic [ANGLE_W-1:0] offset_reg     [NUM_AXES];
    logic [ANGLE_W-1:0] prev_reg       [NUM_AXES];
    logic [TURNS_W-1:0] turns_reg      [NUM_AXES];

    // Pipeline registers.
    logic               s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic               s1_axis_reg, s2_axis_reg, out_axis_reg;
    logic [TURNS_W-1:0] s1_turns_reg, s2_turns_reg, out_turns_reg;
    logic [LOC_W-1:0]   s1_diff_reg, s2_diff_reg;
    logic [LOC_W-1:0]   s2_prod_reg, out_loc_reg;

    logic               out_ready, s2_ready, s1_ready;
    logic               do_pop;
    logic [IDX_W-1:0]   idx;
    logic               seen;
    logic [ANGLE_W-1:0] offset_eff;
    logic [ANGLE_W-1:0] prev_eff;
    logic [TURNS_W-1:0] turns_next;
    logic [LOC_W-1:0]   diff_next;
    logic [LOC_W-1:0]   prod_next;
    logic [LOC_W-1:0]   loc_next;

    // Stall chain from the output register backwards.
    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;
    assign do_pop    = pop_valid && pop_ready;

    // Stage one: state update; a first reading sets the offset and previous angle.
    always_comb begin
        idx        = IDX_W'(pop_item.axis);
        seen       = first_seen_reg[idx];
        offset_eff = seen ? offset_reg[idx] : pop_item.angle;
        prev_eff   = seen ? prev_reg[idx] : pop_item.angle;
        turns_next = turns_reg[idx];
        if ((pop_item.angle < cfg.low_threshold) && (prev_eff > cfg.high_threshold)) begin
            turns_next = turns_reg[idx] + 1'b1;
        end else if ((pop_item.angle > cfg.high_threshold) &&
                     (prev_eff < cfg.low_threshold)) begin
            turns_next = turns_reg[idx] - 1'b1;
        end
        diff_next = {{(LOC_W-ANGLE_W){1'b0}}, pop_item.angle} -
                    {{(LOC_W-ANGLE_W){1'b0}}, offset_eff};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                first_seen_reg[i] <= 1'b0;
                turns_reg[i]      <= '0;
            end
        end else if (do_pop) begin
            first_seen_reg[idx] <= 1'b1;
            turns_reg[idx]      <= turns_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            offset_reg[idx] <= offset_eff;
            prev_reg[idx]   <= pop_item.angle;
        end
    end

    // Stage two: turns times counts per turn, kept to the low 32 bits.
    assign prod_next = {{(LOC_W-TURNS_W){s1_turns_reg[TURNS_W-1]}}, s1_turns_reg} *
                       {{(LOC_W-ANGLE_W){1'b0}}, cfg.counts_per_turn};

    // Stage three: add the angle difference into the output register.
    assign loc_next = s2_prod_reg + s2_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            s1_axis_reg  <= pop_item.axis;
            s1_turns_reg <= turns_next;
            s1_diff_reg  <= diff_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_axis_reg  <= s1_axis_reg;
            s2_turns_reg <= s1_turns_reg;
            s2_diff_reg  <= s1_diff_reg;
            s2_prod_reg  <= prod_next;
        end
        if (out_ready && s2_valid_reg) begin
            out_axis_reg  <= s2_axis_reg;
            out_turns_reg <= s2_turns_reg;
            out_loc_reg   <= loc_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_axis       = out_axis_reg;
    assign m_location   = $signed(out_loc_reg);
    assign m_turn_count = $signed(out_turns_reg);

endmodule

@@ design/multi_turn_encoder_tracker.sv @@
// An accepted request passes through the two-entry queue and then the three-stage
// back end (state update, multiply, add). Throughput: one request per cycle while
// m_ready takes each result; the queue and the back end sustain that rate.
// Requests whose identifier matches neither axis are taken and give no result.
// Reset (aresetn, synchronous, active low) restores the register defaults and
// clears every axis's first-reading flag and turn count.
module multi_turn_encoder_tracker #(
    parameter int NUM_AXES = mtet_pkg::DEFAULT_NUM_AXES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mtet_pkg::IDENT_W-1:0]        s_msg_ident,
    input  logic [mtet_pkg::ANGLE_W-1:0]        s_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_axis,
    output logic signed [mtet_pkg::LOC_W-1:0]   m_location,
    output logic signed [mtet_pkg::TURNS_W-1:0] m_turn_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtet_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mtet_pkg::*;

    cfg_t  cfg_reg;
    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_ident     <= RST_PITCH_IDENT;
            cfg_reg.yaw_ident       <= RST_YAW_IDENT;
            cfg_reg.low_threshold   <= RST_LOW_THRESHOLD;
            cfg_reg.high_threshold  <= RST_HIGH_THRESHOLD;
            cfg_reg.counts_per_turn <= RST_COUNTS_PER_TURN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PITCH_IDENT:     cfg_reg.pitch_ident     <= cfg_data[IDENT_W-1:0];
                REG_YAW_IDENT:       cfg_reg.yaw_ident       <= cfg_data[IDENT_W-1:0];
                REG_LOW_THRESHOLD:   cfg_reg.low_threshold   <= cfg_data;
                REG_HIGH_THRESHOLD:  cfg_reg.high_threshold  <= cfg_data;
                REG_COUNTS_PER_TURN: cfg_reg.counts_per_turn <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: classify by identifier.
    mtet_front #(
        .NUM_AXES(NUM_AXES)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_msg_ident(s_msg_ident),
        .s_angle    (s_angle),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between the two halves.
    mtet_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    // Back end: turn tracking and position.
    mtet_back #(
        .NUM_AXES(NUM_AXES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_axis      (m_axis),
        .m_location  (m_location),
        .m_turn_count(m_turn_count)
    );

endmodule

@@ design/mtet_checker.sv @@
module mtet_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_axis,
    input logic signed [mtet_pkg::LOC_W-1:0]   m_location,
    input logic signed [mtet_pkg::TURNS_W-1:0] m_turn_count,
    input logic                                cfg_ready
);

    // Reset leaves no result pending.
    a_reset_out_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // Reset empties the queue, so requests are taken at once.
    a_reset_in_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge aclk) cfg_ready)
        else $error("configuration port stalled");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_axis) && $stable(m_location)
            && $stable(m_turn_count))
        else $error("result changed while stalled");

endmodule

bind multi_turn_encoder_tracker mtet_checker u_mtet_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_axis      (m_axis),
    .m_location  (m_location),
    .m_turn_count(m_turn_count),
    .cfg_ready   (cfg_ready)
);
